// ===== sv/dhsd_pkg.sv =====
package dhsd_pkg;

  localparam logic [31:0] PngSignature   = 32'h474e5089;
  localparam logic [31:0] CoreSize       = 32'd12;
  localparam logic [31:0] MinInfoSize    = 32'd16;
  localparam logic [31:0] MaxInfoSize    = 32'd124;
  localparam logic [31:0] CompMinSize    = 32'd20;
  localparam logic [31:0] PalMinSize     = 32'd36;
  localparam logic [31:0] MinAvail       = 32'd16;
  localparam logic [31:0] CompRgb        = 32'd0;
  localparam logic [31:0] CompBitfields  = 32'd3;
  localparam logic [3:0]  BitfieldsBytes = 4'd12;
  localparam logic [24:0] ManyColors     = 25'd16777216;
  localparam logic [62:0] TotalLimit     = 63'h7fff_ffff_ffff_ffff;

  localparam int QDepth = 2;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCw    = $clog2(QDepth + 1);

  localparam int SpanW   = 44;
  localparam int SpanLoW = SpanW / 2;
  localparam int SpanHiW = SpanW - SpanLoW;

  typedef enum logic [1:0] {
    ST_INVALID = 2'd0,
    ST_BITMAP  = 2'd1,
    ST_PNG     = 2'd2
  } status_e;

  typedef struct packed {
    status_e      status;
    logic         icon;
    logic [31:0]  width;
    logic [31:0]  height;
    logic [15:0]  depth;
    logic [24:0]  colors;
    logic [6:0]   hsize;
    logic         per4;
    logic [31:0]  pal;
    logic         comp_none;
    logic         comp_bitf;
    logic [31:0]  avail;
  } item_t;

endpackage

// ===== sv/dhsd_front.sv =====
module dhsd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         hdr_size_i,
  input  logic [31:0]         word_at_4_i,
  input  logic [31:0]         word_at_8_i,
  input  logic [31:0]         word_at_12_i,
  input  logic [31:0]         word_at_16_i,
  input  logic [31:0]         word_at_32_i,
  input  logic [31:0]         avail_len_i,
  output logic                fr_valid_o,
  input  logic                fr_ready_i,
  output dhsd_pkg::item_t     fr_item_o
);
  import dhsd_pkg::*;

  logic  icon_q;
  logic  fr_valid_q, fr_valid_d;
  item_t item_q, item_d;

  always_comb begin
    logic [31:0] hgt;
    logic [31:0] pal;
    logic [31:0] comp;
    logic [15:0] dep;
    item_d = '0;
    hgt    = '0;
    pal    = '0;
    comp   = '0;
    dep    = '0;
    if (avail_len_i < MinAvail) begin
      item_d.status = ST_INVALID;
    end else if (hdr_size_i == PngSignature && icon_q) begin
      item_d.status = ST_PNG;
    end else if (hdr_size_i == CoreSize ||
                 hdr_size_i inside {[MinInfoSize:MaxInfoSize]}) begin
      if (hdr_size_i == CoreSize) begin
        item_d.width = {16'b0, word_at_4_i[15:0]};
        hgt          = {16'b0, word_at_4_i[31:16]};
        dep          = word_at_8_i[31:16];
        item_d.per4  = 1'b0;
      end else begin
        item_d.width = word_at_4_i;
        hgt          = word_at_8_i[31] ? (~word_at_8_i + 32'd1) : word_at_8_i;
        dep          = word_at_12_i[31:16];
        item_d.per4  = 1'b1;
        if (hdr_size_i >= CompMinSize) begin
          comp = word_at_16_i;
        end
        if (hdr_size_i >= PalMinSize) begin
          pal = word_at_32_i;
        end
      end
      item_d.height = icon_q ? (hgt >> 1) : hgt;
      if (dep inside {[16'd1:16'd8]}) begin
        item_d.colors = 25'd1 << dep[3:0];
        if (pal == '0) begin
          pal = 32'(item_d.colors);
        end
      end else begin
        item_d.colors = ManyColors;
      end
      item_d.status    = ST_BITMAP;
      item_d.icon      = icon_q;
      item_d.depth     = dep;
      item_d.hsize     = hdr_size_i[6:0];
      item_d.pal       = pal;
      item_d.comp_none = (comp == CompRgb);
      item_d.comp_bitf = (comp == CompBitfields);
      item_d.avail     = avail_len_i;
    end else begin
      item_d.status = ST_INVALID;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !fr_valid_q || fr_ready_i;
  assign fr_valid_d  = in_ready_o ? in_valid_i : fr_valid_q;
  assign fr_valid_o  = fr_valid_q;
  assign fr_item_o   = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icon_q     <= 1'b0;
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        icon_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== sv/dhsd_queue.sv =====
module dhsd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  dhsd_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output dhsd_pkg::item_t pop_item_o
);
  import dhsd_pkg::*;

  item_t            mem_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCw-1:0]   count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != QCw'(QDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    case ({push, pop})
      2'b10:   count_d = count_q + QCw'(1);
      2'b01:   count_d = count_q - QCw'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QAw'(QDepth - 1)) ? '0 : wr_ptr_q + QAw'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QAw'(QDepth - 1)) ? '0 : rd_ptr_q + QAw'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== sv/dhsd_back.sv =====
module dhsd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            bk_valid_i,
  output logic            bk_ready_o,
  input  dhsd_pkg::item_t bk_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      status_o,
  output logic [31:0]     width_o,
  output logic [31:0]     height_o,
  output logic [24:0]     color_count_o,
  output logic [34:0]     header_bytes_o,
  output logic [62:0]     total_bytes_o,
  output logic            size_saturated_o
);
  import dhsd_pkg::*;

  typedef struct packed {
    status_e      status;
    logic [31:0]  width;
    logic [31:0]  height;
    logic [24:0]  colors;
    logic         comp_none;
    logic [31:0]  avail;
    logic [34:0]  hdr;
  } carry_t;

  logic   v1_q, v2_q, v3_q, v4_q, v5_q;
  logic   advance, pop;
  carry_t c1_d, c1_q, c2_q, c3_q, c4_q, c5_q;

  logic [47:0]          dw1_d, dw1_q;
  logic [27:0]          maskw1_d, maskw1_q;
  logic [SpanW-1:0]     spanw2_d, spanw2_q;
  logic [59:0]          mask2_d, mask2_q, mask3_q, mask4_q;
  logic [SpanLoW+31:0]  pl3_d, pl3_q;
  logic [SpanHiW+31:0]  ph3_d, ph3_q;
  logic [63:0]          fg4_d, fg4_q;
  logic [62:0]          total5_d, total5_q;
  logic                 sat5_d, sat5_q;

  assign advance    = !v5_q || out_ready_i;
  assign pop        = advance && bk_valid_i;
  assign bk_ready_o = advance;

  always_comb begin
    logic [34:0] pal_x;
    logic [32:0] wsum;
    pal_x = bk_item_i.per4 ? {1'b0, bk_item_i.pal, 2'b00}
                           : ({3'b0, bk_item_i.pal} + {2'b0, bk_item_i.pal, 1'b0});
    wsum  = {1'b0, bk_item_i.width} + 33'd31;
    c1_d.status    = bk_item_i.status;
    c1_d.width     = bk_item_i.width;
    c1_d.height    = bk_item_i.height;
    c1_d.colors    = bk_item_i.colors;
    c1_d.comp_none = bk_item_i.comp_none;
    c1_d.avail     = bk_item_i.avail;
    c1_d.hdr       = 35'(bk_item_i.hsize) + pal_x
                   + (bk_item_i.comp_bitf ? 35'(BitfieldsBytes) : 35'd0);
    dw1_d          = 48'(bk_item_i.depth) * 48'(bk_item_i.width);
    maskw1_d       = bk_item_i.icon ? wsum[32:5] : '0;
  end

  always_comb begin
    logic [48:0] dsum;
    dsum     = {1'b0, dw1_q} + 49'd31;
    spanw2_d = dsum[48:5];
    mask2_d  = 60'(maskw1_q) * 60'(c1_q.height);
  end

  assign pl3_d = (SpanLoW + 32)'(spanw2_q[SpanLoW-1:0]) * (SpanLoW + 32)'(c2_q.height);
  assign ph3_d = (SpanHiW + 32)'(spanw2_q[SpanW-1:SpanLoW]) * (SpanHiW + 32)'(c2_q.height);

  always_comb begin
    logic [SpanW+33:0] fg;
    fg    = ((SpanW + 34)'(pl3_q) + ((SpanW + 34)'(ph3_q) << SpanLoW)) << 2;
    fg4_d = (|fg[SpanW+33:63]) ? {1'b1, 63'b0} : {1'b0, fg[62:0]};
  end

  always_comb begin
    logic [64:0] sum;
    logic        sat;
    sum = 65'(fg4_q) + 65'(c4_q.hdr) + 65'({mask4_q, 2'b00});
    sat = |sum[64:63];
    if (c4_q.comp_none) begin
      total5_d = sat ? TotalLimit : sum[62:0];
    end else begin
      total5_d = 63'(c4_q.avail);
    end
    sat5_d = c4_q.comp_none && sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (advance) begin
      v1_q <= pop;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      c1_q     <= c1_d;
      dw1_q    <= dw1_d;
      maskw1_q <= maskw1_d;
      c2_q     <= c1_q;
      spanw2_q <= spanw2_d;
      mask2_q  <= mask2_d;
      c3_q     <= c2_q;
      pl3_q    <= pl3_d;
      ph3_q    <= ph3_d;
      mask3_q  <= mask2_q;
      c4_q     <= c3_q;
      fg4_q    <= fg4_d;
      mask4_q  <= mask3_q;
      c5_q     <= c4_q;
      total5_q <= total5_d;
      sat5_q   <= sat5_d;
    end
  end

  assign out_valid_o      = v5_q;
  assign status_o         = c5_q.status;
  assign width_o          = c5_q.width;
  assign height_o         = c5_q.height;
  assign color_count_o    = c5_q.colors;
  assign header_bytes_o   = c5_q.hdr;
  assign total_bytes_o    = total5_q;
  assign size_saturated_o = sat5_q;

endmodule

// ===== sv/dib_header_size_decoder_unit.sv =====
// A result passes through the front-end output register, the queue and the back-end pipeline
// registers in that order before it appears on the outputs.
// Throughput: one item per cycle; the multiplier pipeline in the back end advances each cycle
// unless the output register holds a result that is not taken.
// A two-entry queue separates the classify stage from the arithmetic pipeline.
// Reset (rst_ni low, asynchronous) empties all stages and the queue and clears icon_mode to 0.
module dib_header_size_decoder_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_data_i,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [31:0]  hdr_size_i,
  input  logic [31:0]  word_at_4_i,
  input  logic [31:0]  word_at_8_i,
  input  logic [31:0]  word_at_12_i,
  input  logic [31:0]  word_at_16_i,
  input  logic [31:0]  word_at_32_i,
  input  logic [31:0]  avail_len_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [1:0]   status_o,
  output logic [31:0]  width_o,
  output logic [31:0]  height_o,
  output logic [24:0]  color_count_o,
  output logic [34:0]  header_bytes_o,
  output logic [62:0]  total_bytes_o,
  output logic         size_saturated_o
);
  import dhsd_pkg::*;

  logic  fr_valid, fr_ready;
  item_t fr_item;
  logic  bk_valid, bk_ready;
  item_t bk_item;

  dhsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .hdr_size_i   (hdr_size_i),
    .word_at_4_i  (word_at_4_i),
    .word_at_8_i  (word_at_8_i),
    .word_at_12_i (word_at_12_i),
    .word_at_16_i (word_at_16_i),
    .word_at_32_i (word_at_32_i),
    .avail_len_i  (avail_len_i),
    .fr_valid_o   (fr_valid),
    .fr_ready_i   (fr_ready),
    .fr_item_o    (fr_item)
  );

  dhsd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_item_o   (bk_item)
  );

  dhsd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .bk_valid_i       (bk_valid),
    .bk_ready_o       (bk_ready),
    .bk_item_i        (bk_item),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .width_o          (width_o),
    .height_o         (height_o),
    .color_count_o    (color_count_o),
    .header_bytes_o   (header_bytes_o),
    .total_bytes_o    (total_bytes_o),
    .size_saturated_o (size_saturated_o)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import dhsd_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int DrainCycles  = 12;
  localparam int RandomPhases = 6;
  localparam int PhaseItems   = 150;

  typedef struct packed {
    logic [31:0] hdr_size;
    logic [31:0] word_at_4;
    logic [31:0] word_at_8;
    logic [31:0] word_at_12;
    logic [31:0] word_at_16;
    logic [31:0] word_at_32;
    logic [31:0] avail_len;
  } dib_header_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] width;
    logic [31:0] height;
    logic [24:0] color_count;
    logic [34:0] header_bytes;
    logic [62:0] total_bytes;
    logic        size_saturated;
  } dib_decode_t;

  typedef struct {
    bit          icon;
    dib_header_t hdr;
    bit          typed;
    dib_decode_t want;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] hdr_size_i = '0;
  logic [31:0] word_at_4_i = '0;
  logic [31:0] word_at_8_i = '0;
  logic [31:0] word_at_12_i = '0;
  logic [31:0] word_at_16_i = '0;
  logic [31:0] word_at_32_i = '0;
  logic [31:0] avail_len_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] width_o;
  logic [31:0] height_o;
  logic [24:0] color_count_o;
  logic [34:0] header_bytes_o;
  logic [62:0] total_bytes_o;
  logic        size_saturated_o;

  dib_decode_t   expected_decodes[$];
  directed_row_t directed_rows[$];
  dib_decode_t   head_want;
  bit            icon_mode_q = 1'b0;
  bit            calm = 1'b0;
  int            errors = 0;
  int            cycle_count = 0;
  int            n_directed = 0;
  int            n_random = 0;
  int            n_mode_writes = 0;
  int            n_bitmap = 0;
  int            n_png = 0;
  int            n_invalid = 0;
  int            n_saturated = 0;

  dib_header_size_decoder_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
  end

  function automatic dib_decode_t decode_header(input bit icon, input dib_header_t h);
    dib_decode_t  r;
    logic [63:0]  wid, hgt, dep, comp, pal, colors, hb, per;
    logic [127:0] span, sum;
    r = '0;
    comp = '0;
    pal = '0;
    if (h.avail_len < MinAvail) return r;
    if (icon && h.hdr_size == PngSignature) begin
      r.status = ST_PNG;
      return r;
    end else if (h.hdr_size == CoreSize) begin
      per = 3;
      wid = h.word_at_4[15:0];
      hgt = h.word_at_4[31:16];
      dep = h.word_at_8[31:16];
    end else if (h.hdr_size >= MinInfoSize && h.hdr_size <= MaxInfoSize) begin
      per = 4;
      wid = h.word_at_4;
      hgt = h.word_at_8[31] ? 64'h1_0000_0000 - h.word_at_8 : {32'd0, h.word_at_8};
      dep = h.word_at_12[31:16];
      if (h.hdr_size >= CompMinSize) comp = h.word_at_16;
      if (h.hdr_size >= PalMinSize) pal = h.word_at_32;
    end else begin
      return r;
    end
    if (icon) hgt = hgt >> 1;
    if (dep >= 1 && dep <= 8) begin
      colors = 64'd1 << dep;
      if (pal == 0) pal = colors;
    end else begin
      colors = ManyColors;
    end
    hb = h.hdr_size + per * pal;
    if (comp == CompBitfields) hb = hb + BitfieldsBytes;
    if (comp == CompRgb) begin
      span = ((dep * wid + 31) / 32) * 4;
      sum = hb + span * hgt;
      if (icon) sum = sum + ((wid + 31) / 32) * 4 * hgt;
      if (sum > TotalLimit) begin
        r.total_bytes = TotalLimit;
        r.size_saturated = 1'b1;
      end else begin
        r.total_bytes = sum[62:0];
      end
    end else begin
      r.total_bytes = h.avail_len;
    end
    r.status = ST_BITMAP;
    r.width = wid[31:0];
    r.height = hgt[31:0];
    r.color_count = colors[24:0];
    r.header_bytes = hb[34:0];
    return r;
  endfunction

  function automatic logic [15:0] pick_depth();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd2;
      3: return 16'd4;
      4: return 16'd8;
      5: return 16'd16;
      6: return 16'd24;
      7: return 16'd32;
      8: return 16'($urandom_range(3, 7));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic dib_header_t random_header();
    dib_header_t h;
    int          kind;
    int          sel;
    kind = $urandom_range(0, 99);
    h.word_at_4 = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2000) : $urandom();
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      h.word_at_8 = $urandom_range(0, 1000);
      if ($urandom_range(0, 1)) h.word_at_8 = -h.word_at_8;
    end else if (sel == 6) begin
      h.word_at_8 = 32'h8000_0000;
    end else begin
      h.word_at_8 = $urandom();
    end
    h.word_at_12 = {pick_depth(), 16'($urandom())};
    sel = $urandom_range(0, 9);
    h.word_at_16 = (sel < 5) ? CompRgb : (sel < 7) ? CompBitfields :
                   (sel < 9) ? $urandom_range(1, 2) : $urandom();
    sel = $urandom_range(0, 9);
    h.word_at_32 = (sel < 4) ? 32'd0 : (sel < 8) ? $urandom_range(0, 256) : $urandom();
    sel = $urandom_range(0, 99);
    h.avail_len = (sel < 8) ? $urandom_range(0, 15) : (sel < 16) ? MinAvail : $urandom();
    if (kind < 12) begin
      h.hdr_size = CoreSize;
      if ($urandom_range(0, 3) != 0)
        h.word_at_4 = {16'($urandom_range(0, 300)), 16'($urandom_range(0, 300))};
      h.word_at_8 = {pick_depth(), 16'($urandom())};
    end else if (kind < 72) begin
      case ($urandom_range(0, 7))
        0: h.hdr_size = MinInfoSize;
        1: h.hdr_size = CompMinSize;
        2: h.hdr_size = PalMinSize;
        3: h.hdr_size = 32'd40;
        4: h.hdr_size = 32'd108;
        5: h.hdr_size = MaxInfoSize;
        default: h.hdr_size = $urandom_range(16, 124);
      endcase
    end else if (kind < 78) begin
      h.hdr_size = PngSignature;
    end else if (kind < 88) begin
      case ($urandom_range(0, 3))
        0: h.hdr_size = $urandom_range(0, 11);
        1: h.hdr_size = $urandom_range(13, 15);
        2: h.hdr_size = $urandom_range(125, 200);
        default: h.hdr_size = $urandom();
      endcase
    end else begin
      h = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom()};
    end
    return h;
  endfunction

  task automatic match_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_decodes.size() == 0) begin
        $error("result transfer with no decode pending: status 0x%0h", status_o);
        errors++;
      end else begin
        head_want = expected_decodes.pop_front();
        match_field("status", head_want.status, status_o);
        match_field("width", head_want.width, width_o);
        match_field("height", head_want.height, height_o);
        match_field("color_count", head_want.color_count, color_count_o);
        match_field("header_bytes", head_want.header_bytes, header_bytes_o);
        match_field("total_bytes", head_want.total_bytes, total_bytes_o);
        match_field("size_saturated", head_want.size_saturated, size_saturated_o);
      end
      case (status_o)
        ST_BITMAP: n_bitmap++;
        ST_PNG:    n_png++;
        default:   n_invalid++;
      endcase
      if (size_saturated_o) n_saturated++;
    end
  end

  task automatic send_header(input dib_header_t h, input bit typed, input dib_decode_t want);
    bit taken;
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    hdr_size_i   <= h.hdr_size;
    word_at_4_i  <= h.word_at_4;
    word_at_8_i  <= h.word_at_8;
    word_at_12_i <= h.word_at_12;
    word_at_16_i <= h.word_at_16;
    word_at_32_i <= h.word_at_32;
    avail_len_i  <= h.avail_len;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end
    expected_decodes.push_back(typed ? want : decode_header(icon_mode_q, h));
  endtask

  task automatic write_icon_mode(input bit mode);
    bit taken;
    in_valid_i <= 1'b0;
    while (expected_decodes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    icon_mode_q = mode;
    n_mode_writes++;
  endtask

  task automatic add_row(input bit icon, input logic [31:0] hs, w4, w8, w12, w16, w32,
                         avail, input bit typed, input dib_decode_t want);
    directed_row_t row;
    row.icon = icon;
    row.hdr = {hs, w4, w8, w12, w16, w32, avail};
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  initial begin
    dib_decode_t invalid_res, png_res, sat_res;
    invalid_res = '0;
    png_res = '0;
    png_res.status = ST_PNG;
    sat_res.status = ST_BITMAP;
    sat_res.width = 32'hffff_ffff;
    sat_res.height = 32'h7fff_ffff;
    sat_res.color_count = ManyColors;
    sat_res.header_bytes = 35'd40;
    sat_res.total_bytes = TotalLimit;
    sat_res.size_saturated = 1'b1;

    add_row(0, 40, 100, 50, 32'h0008_0000, 0, 0, 0, 1, invalid_res);
    add_row(0, 40, 100, 50, 32'h0008_0000, 0, 0, 15, 1, invalid_res);
    add_row(0, 0, 100, 50, 32'h0008_0000, 0, 0, 16, 1, invalid_res);
    add_row(0, 11, 100, 50, 32'h0008_0000, 0, 0, 1000, 1, invalid_res);
    add_row(0, 13, 100, 50, 32'h0008_0000, 0, 0, 1000, 1, invalid_res);
    add_row(0, 15, 100, 50, 32'h0008_0000, 0, 0, 1000, 1, invalid_res);
    add_row(0, 125, 100, 50, 32'h0008_0000, 0, 0, 1000, 1, invalid_res);
    add_row(0, 32'hffff_ffff, 100, 50, 32'h0008_0000, 0, 0, 1000, 1, invalid_res);
    add_row(0, PngSignature, 100, 50, 32'h0008_0000, 0, 0, 1000, 1, invalid_res);
    add_row(0, 12, 32'h0002_0003, 32'h0018_0000, 0, 0, 0, 64, 0, invalid_res);
    add_row(0, 12, 32'hffff_ffff, 32'h0001_ffff, 0, 0, 0, 32'hffff_ffff, 0, invalid_res);
    add_row(0, 16, 640, 480, 32'h0008_0000, 3, 5, 5000, 0, invalid_res);
    add_row(0, 20, 33, 7, 32'h0010_0000, CompBitfields, 9, 5000, 0, invalid_res);
    add_row(0, 36, 17, 9, 32'h0008_0000, 0, 0, 5000, 0, invalid_res);
    add_row(0, 40, 65, 32'h8000_0000, 32'h0004_0000, 0, 7, 32'hffff_ffff, 0, invalid_res);
    add_row(0, 40, 5, 32'hffff_fffd, 32'h0002_0000, 0, 0, 100, 0, invalid_res);
    add_row(0, 124, 200, 100, 32'h0020_0000, 1, 0, 12345, 0, invalid_res);
    add_row(0, 124, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
            32'hffff_ffff, 32'hffff_ffff, 0, invalid_res);
    add_row(0, 40, 32'hffff_ffff, 32'h7fff_ffff, 32'hffff_0000, 0, 0, 32'hffff_ffff,
            1, sat_res);
    add_row(1, PngSignature, 0, 0, 0, 0, 0, 16, 1, png_res);
    add_row(1, PngSignature, 0, 0, 0, 0, 0, 15, 1, invalid_res);
    add_row(1, 12, 32'h0021_0011, 32'h0004_0000, 0, 0, 0, 300, 0, invalid_res);
    add_row(1, 40, 31, 32'hffff_ffe1, 32'h0001_0000, 0, 2, 400, 0, invalid_res);
    add_row(1, 40, 32'hffff_ffff, 32'h7fff_ffff, 32'h0020_0000, 0, 0, 99, 0, invalid_res);
    add_row(1, 108, 48, 48, 32'h0020_0000, CompBitfields, 0, 777, 0, invalid_res);
    add_row(1, 0, 48, 48, 32'h0020_0000, 0, 0, 777, 1, invalid_res);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_icon_mode(1'b0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].icon != icon_mode_q) write_icon_mode(directed_rows[i].icon);
      send_header(directed_rows[i].hdr, directed_rows[i].typed, directed_rows[i].want);
      n_directed++;
    end

    for (int p = 0; p < RandomPhases; p++) begin
      write_icon_mode(p[0]);
      calm = (p == 2);
      repeat (PhaseItems) begin
        send_header(random_header(), 1'b0, invalid_res);
        n_random++;
      end
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    while (expected_decodes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d directed and %0d random headers across %0d icon_mode writes",
             n_directed, n_random, n_mode_writes);
    $display("Results: %0d decoded, %0d PNG, %0d rejected, %0d saturated",
             n_bitmap, n_png, n_invalid, n_saturated);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/dhsd_pkg.sv
sv/dhsd_front.sv
sv/dhsd_queue.sv
sv/dhsd_back.sv
sv/dib_header_size_decoder_unit.sv
bench/tb_top.sv
